// File: sv/tcw_pkg.sv
// Package for the text console writer: microcode word layout, step labels,
// the microcode program itself and shared constants.
// No dependencies; imported by every module of the block but tcw_ram.
package tcw_pkg;

    // Fixed field widths of the stream payload
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ADDR_W = 11;

    // Cell contents
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]        ATTR_BYTE  = 8'h07;

    // Control codes in put mode
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    // Microprogram step index
    typedef logic [4:0] t_step;

    localparam t_step ST_RST0  = 5'd0;
    localparam t_step ST_RST1  = 5'd1;
    localparam t_step ST_IDLE  = 5'd2;
    localparam t_step ST_CHAR  = 5'd3;
    localparam t_step ST_CHECK = 5'd4;
    localparam t_step ST_EMIT  = 5'd5;
    localparam t_step ST_NL    = 5'd6;
    localparam t_step ST_BS0   = 5'd7;
    localparam t_step ST_BS1   = 5'd8;
    localparam t_step ST_RD0   = 5'd9;
    localparam t_step ST_RD1   = 5'd10;
    localparam t_step ST_RD2   = 5'd11;
    localparam t_step ST_CLR0  = 5'd12;
    localparam t_step ST_CLR1  = 5'd13;
    localparam t_step ST_CLR2  = 5'd14;
    localparam t_step ST_SC0   = 5'd15;
    localparam t_step ST_SC1   = 5'd16;
    localparam t_step ST_SC2   = 5'd17;
    localparam t_step ST_SC3   = 5'd18;
    localparam t_step ST_SC4   = 5'd19;

    // Jump conditions
    typedef enum logic [3:0] {
        JC_NEXT,          // never jump
        JC_ALWAYS,
        JC_DISPATCH,      // input transfer; target comes from the request
        JC_PTR_NOT_LAST,
        JC_SRC_NOT_LAST,
        JC_SCROLL,
        JC_COL_ZERO,
        JC_ADDR_BAD,
        JC_OUT_FREE
    } t_cond;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_WR_BLANK,
        MEM_WR_CHAR,
        MEM_WR_MOVE,
        MEM_RD
    } t_mem_op;

    typedef enum logic [2:0] {
        ADDR_PTR,
        ADDR_SRC,
        ADDR_POS,
        ADDR_POS_DEC,
        ADDR_REQ
    } t_addr_sel;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC
    } t_ptr_op;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_ADV,
        CUR_NL,
        CUR_BACK
    } t_cur_op;

    // One control word
    typedef struct packed {
        t_cond     cond;
        t_step     target;
        logic      hold;       // stay on this step while cond is false
        logic      accept;     // input ready
        logic      emit;       // load the output register when it is free
        logic      load_cell;  // capture RAM read data as result cell
        t_mem_op   mem;
        t_addr_sel addr;
        t_ptr_op   ptr;
        t_cur_op   cur;
    } t_ucode;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic  in_valid;
        t_step disp_step;
        logic  ptr_last;
        logic  src_last;
        logic  scroll;
        logic  col_zero;
        logic  addr_bad;
        logic  out_free;
    } t_status;

    localparam t_ucode UC_NOP = '{
        cond: JC_NEXT, target: ST_IDLE, hold: 1'b0, accept: 1'b0, emit: 1'b0,
        load_cell: 1'b0, mem: MEM_NONE, addr: ADDR_PTR, ptr: PTR_HOLD, cur: CUR_HOLD
    };

    // Microprogram ROM
    function automatic t_ucode ucode(input t_step step);
        t_ucode uc;
        uc = UC_NOP;
        case (step)
            // power-up sweep: blank every cell, home the cursor
            ST_RST0: begin
                uc.ptr = PTR_ZERO;
                uc.cur = CUR_HOME;
            end
            ST_RST1: begin
                uc.mem = MEM_WR_BLANK; uc.addr = ADDR_PTR; uc.ptr = PTR_INC;
                uc.cond = JC_PTR_NOT_LAST; uc.target = ST_RST1;
            end
            ST_IDLE: begin
                uc.accept = 1'b1; uc.hold = 1'b1; uc.cond = JC_DISPATCH;
            end
            // printable byte
            ST_CHAR: begin
                uc.mem = MEM_WR_CHAR; uc.addr = ADDR_POS; uc.cur = CUR_ADV;
            end
            ST_CHECK: begin
                uc.cond = JC_SCROLL; uc.target = ST_SC0;
            end
            ST_EMIT: begin
                uc.emit = 1'b1; uc.hold = 1'b1;
                uc.cond = JC_OUT_FREE; uc.target = ST_IDLE;
            end
            ST_NL: begin
                uc.cur = CUR_NL; uc.cond = JC_ALWAYS; uc.target = ST_CHECK;
            end
            // backspace
            ST_BS0: begin
                uc.cond = JC_COL_ZERO; uc.target = ST_EMIT;
            end
            ST_BS1: begin
                uc.mem = MEM_WR_BLANK; uc.addr = ADDR_POS_DEC; uc.cur = CUR_BACK;
                uc.cond = JC_ALWAYS; uc.target = ST_EMIT;
            end
            // read one cell
            ST_RD0: begin
                uc.cond = JC_ADDR_BAD; uc.target = ST_EMIT;
            end
            ST_RD1: begin
                uc.mem = MEM_RD; uc.addr = ADDR_REQ;
            end
            ST_RD2: begin
                uc.load_cell = 1'b1; uc.cond = JC_ALWAYS; uc.target = ST_EMIT;
            end
            // clear screen
            ST_CLR0: begin
                uc.ptr = PTR_ZERO; uc.cur = CUR_HOME;
            end
            ST_CLR1: begin
                uc.mem = MEM_WR_BLANK; uc.addr = ADDR_PTR; uc.ptr = PTR_INC;
                uc.cond = JC_PTR_NOT_LAST; uc.target = ST_CLR1;
            end
            ST_CLR2: begin
                uc.cond = JC_ALWAYS; uc.target = ST_EMIT;
            end
            // scroll: move each cell up one row, then blank the last row
            ST_SC0: begin
                uc.ptr = PTR_ZERO;
            end
            ST_SC1: begin
                uc.mem = MEM_RD; uc.addr = ADDR_SRC;
            end
            ST_SC2: begin
                uc.mem = MEM_WR_MOVE; uc.addr = ADDR_PTR; uc.ptr = PTR_INC;
                uc.cond = JC_SRC_NOT_LAST; uc.target = ST_SC1;
            end
            ST_SC3: begin
                uc.mem = MEM_WR_BLANK; uc.addr = ADDR_PTR; uc.ptr = PTR_INC;
                uc.cond = JC_PTR_NOT_LAST; uc.target = ST_SC3;
            end
            ST_SC4: begin
                uc.cond = JC_ALWAYS; uc.target = ST_EMIT;
            end
            default: begin
                uc.cond = JC_ALWAYS; uc.target = ST_RST0;
            end
        endcase
        return uc;
    endfunction

endpackage

// File: sv/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: sv/tcw_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on tcw_pkg.
module tcw_sequencer
    import tcw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ucode  o_cw
);

    t_step  r_step;
    t_step  n_step;
    t_ucode cw;
    logic   take;

    assign cw   = ucode(r_step);
    assign o_cw = cw;

    // jump condition
    always_comb begin
        case (cw.cond)
            JC_NEXT:         take = 1'b0;
            JC_ALWAYS:       take = 1'b1;
            JC_DISPATCH:     take = i_status.in_valid;
            JC_PTR_NOT_LAST: take = !i_status.ptr_last;
            JC_SRC_NOT_LAST: take = !i_status.src_last;
            JC_SCROLL:       take = i_status.scroll;
            JC_COL_ZERO:     take = i_status.col_zero;
            JC_ADDR_BAD:     take = i_status.addr_bad;
            JC_OUT_FREE:     take = i_status.out_free;
            default:         take = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (take) begin
            n_step = (cw.cond == JC_DISPATCH) ? i_status.disp_step : cw.target;
        end else if (cw.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_RST0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: sv/tcw_datapath.sv
// Datapath: cursor registers, sweep pointer, request latch, output register
// and the cell store RAM. Depends on tcw_pkg and tcw_ram.
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ucode      i_cw,
    output t_status     o_status,
    // input stream
    input  logic        i_s_axis_tvalid,
    input  logic [23:0] i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser,
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_SRC  = AW'(CELLS - 1 - COLUMNS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

    // request fields
    logic [7:0]        in_char;
    logic [ADDR_W-1:0] in_addr;
    t_mode             in_mode;
    logic              accept;

    assign in_char = i_s_axis_tdata[7:0];
    assign in_addr = i_s_axis_tdata[18:8];
    assign in_mode = t_mode'(i_s_axis_tuser);
    assign accept  = i_cw.accept && i_s_axis_tvalid;

    // registers
    logic [AW-1:0]     r_ptr,  n_ptr;
    logic [AW-1:0]     r_pos,  n_pos;
    logic [AW-1:0]     r_base, n_base;
    logic [CW-1:0]     r_col,  n_col;
    logic [RW-1:0]     r_row,  n_row;
    logic              r_scroll, n_scroll;
    logic [7:0]        r_char;
    logic [ADDR_W-1:0] r_addr;
    logic [CELL_W-1:0] r_cell;
    logic              r_out_valid;
    logic [31:0]       r_out_data;

    logic              out_free;
    logic              emit;
    logic [AW-1:0]     src;
    logic [AW-1:0]     next_base;
    logic [AW-1:0]     ram_addr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    logic              ram_we;
    logic              ram_re;
    t_step             disp_step;

    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign emit      = i_cw.emit && out_free;
    assign src       = r_ptr + ROW_STEP;
    assign next_base = r_base + ROW_STEP;

    // dispatch target from the incoming request
    always_comb begin
        case (in_mode)
            MODE_PUT: begin
                if (in_char == CHAR_NEWLINE) begin
                    disp_step = ST_NL;
                end else if (in_char == CHAR_BACKSPACE) begin
                    disp_step = ST_BS0;
                end else begin
                    disp_step = ST_CHAR;
                end
            end
            MODE_CLEAR: disp_step = ST_CLR0;
            MODE_READ:  disp_step = ST_RD0;
            default:    disp_step = ST_EMIT;
        endcase
    end

    // status to the sequencer
    always_comb begin
        o_status.in_valid  = i_s_axis_tvalid;
        o_status.disp_step = disp_step;
        o_status.ptr_last  = (r_ptr == LAST_CELL);
        o_status.src_last  = (r_ptr == LAST_SRC);
        o_status.scroll    = r_scroll;
        o_status.col_zero  = (r_col == '0);
        o_status.addr_bad  = (32'(r_addr) >= 32'(CELLS));
        o_status.out_free  = out_free;
    end

    // sweep pointer
    always_comb begin
        case (i_cw.ptr)
            PTR_ZERO: n_ptr = '0;
            PTR_INC:  n_ptr = r_ptr + AW'(1);
            default:  n_ptr = r_ptr;
        endcase
    end

    // cursor update; a wrap off the last row flags a scroll
    always_comb begin
        n_pos    = r_pos;
        n_base   = r_base;
        n_col    = r_col;
        n_row    = r_row;
        n_scroll = accept ? 1'b0 : r_scroll;
        case (i_cw.cur)
            CUR_HOME: begin
                n_pos  = '0;
                n_base = '0;
                n_col  = '0;
                n_row  = '0;
            end
            CUR_ADV, CUR_NL: begin
                if (i_cw.cur == CUR_ADV && r_col != LAST_COL) begin
                    n_col = r_col + CW'(1);
                    n_pos = r_pos + AW'(1);
                end else begin
                    n_col = '0;
                    if (r_row != LAST_ROW) begin
                        n_row  = r_row + RW'(1);
                        n_base = next_base;
                        n_pos  = next_base;
                    end else begin
                        n_pos    = r_base;
                        n_scroll = 1'b1;
                    end
                end
            end
            CUR_BACK: begin
                n_col = r_col - CW'(1);
                n_pos = r_pos - AW'(1);
            end
            default: ;
        endcase
    end

    // RAM address and write data
    always_comb begin
        case (i_cw.addr)
            ADDR_PTR:     ram_addr = r_ptr;
            ADDR_SRC:     ram_addr = src;
            ADDR_POS:     ram_addr = r_pos;
            ADDR_POS_DEC: ram_addr = r_pos - AW'(1);
            ADDR_REQ:     ram_addr = AW'(r_addr);
            default:      ram_addr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cw.mem)
            MEM_WR_CHAR: ram_wdata = {ATTR_BYTE, r_char};
            MEM_WR_MOVE: ram_wdata = ram_rdata;
            default:     ram_wdata = BLANK_CELL;
        endcase
    end

    assign ram_we = (i_cw.mem == MEM_WR_BLANK) || (i_cw.mem == MEM_WR_CHAR) ||
                    (i_cw.mem == MEM_WR_MOVE);
    assign ram_re = (i_cw.mem == MEM_RD);

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_pos       <= '0;
            r_base      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_scroll    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr    <= n_ptr;
            r_pos    <= n_pos;
            r_base   <= n_base;
            r_col    <= n_col;
            r_row    <= n_row;
            r_scroll <= n_scroll;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= in_char;
            r_addr <= in_addr;
        end
        if (accept) begin
            r_cell <= '0;
        end else if (i_cw.load_cell) begin
            r_cell <= ram_rdata;
        end
        if (emit) begin
            r_out_data <= {4'd0, r_scroll, r_cell, POS_W'(r_pos)};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: sv/text_console_writer.sv
// Text console writer: microcoded engine over a ROWS x COLUMNS cell store, one item in work.
// Character or newline: write or cursor step, scroll check, then the emit step loads the result.
// Backspace: nothing in column 0; a read past the store skips the RAM; mode three emits at once;
// clear blanks every cell and a scroll moves every row up; these loops go over one RAM port.
// A result held by the receiver stalls the engine in its emit step.
// After reset the cursor is homed and a sweep blanks the store, tready low.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [7:0] char_code, [18:8] cell_address
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] mode
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // [10:0] cursor_position, [26:11] cell_data,
                                         // [27] scrolled
);

    t_ucode  cw;
    t_status status;

    tcw_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cw     (cw)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cw            (cw),
        .o_status        (status),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    assign o_s_axis_tready = cw.accept;

endmodule

// File: verif/tb_text_console_writer.sv
// Self-checking testbench for text_console_writer: directed and random console traffic
// over the stream ports, with results checked against an in-bench model of the screen.
// Depends on tcw_pkg (request kinds, cell and control-code constants) and the RTL top.
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;
    // Busiest run: ~1200 transfers, each a full scroll plus gaps and stalls, plus the power-up
    // sweep; taken about three times over.
    localparam int CYCLE_LIMIT = 15_000_000;
    localparam int END_SETTLE  = 20;
    localparam int MAX_REPORTS = 100;

    // One result transfer, fields from the highest bit down
    typedef struct packed {
        logic        scrolled;
        logic [15:0] cell_data;
        logic [10:0] position;
    } t_console_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // [7:0] char_code, [18:8] cell_address
    logic [1:0]  s_axis_tuser = '0;  // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // [10:0] cursor_position, [26:11] cell_data, [27] scrolled

    // Screen model
    logic [15:0] screen [CELLS];
    int unsigned cur_col;
    int unsigned cur_row;

    t_console_result expected_results[$];
    t_console_result got_result;
    t_console_result want_result;
    int          err_count = 0;
    longint      cycle_count = 0;
    int          sink_hold_cycles = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;

    text_console_writer #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_axis_tvalid),
        .o_s_axis_tready(s_axis_tready),
        .i_s_axis_tdata (s_axis_tdata),
        .i_s_axis_tuser (s_axis_tuser),
        .o_m_axis_tvalid(m_axis_tvalid),
        .i_m_axis_tready(m_axis_tready),
        .o_m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        // keep the log bounded on a badly broken build; every mismatch still counts
        if (err_count < MAX_REPORTS)
            $display("mismatch %s: got 0x%0h expected 0x%0h (cycle %0d)",
                     what, got, want, cycle_count);
        err_count++;
    endtask

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen[i] = BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
    endfunction

    // Apply one request to the screen model and return the result it should give
    function automatic t_console_result console_step(input t_mode m, input logic [7:0] code,
                                                     input logic [10:0] addr);
        t_console_result r;
        r = '0;
        case (m)
            MODE_PUT: begin
                if (code == CHAR_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (code == CHAR_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen[cur_row * COLS + cur_col] = BLANK_CELL;
                    end
                end else begin
                    // raw byte, no sign extension
                    screen[cur_row * COLS + cur_col] = {ATTR_BYTE, code};
                    cur_col++;
                end
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // past the last row: move everything up one row
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLS; i++)
                        screen[i] = screen[i + COLS];
                    for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
                        screen[i] = BLANK_CELL;
                    cur_row = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            MODE_CLEAR: blank_screen();
            MODE_READ: begin
                if (addr < CELLS)
                    r.cell_data = screen[addr];
            end
            default: ;
        endcase
        r.position = POS_W'(cur_row * COLS + cur_col);
        return r;
    endfunction

    // Half anywhere in the address space (past the store too), half on the cursor row
    function automatic logic [10:0] read_address();
        if ($urandom_range(1) == 1)
            return 11'($urandom);
        return POS_W'(cur_row * COLS + $urandom_range(0, COLS - 1));
    endfunction

    // Entered and left at a falling edge; valid stays up for back-to-back transfers
    task automatic send_item(input t_mode m, input logic [7:0] code, input logic [10:0] addr);
        if (src_idle_en && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, addr, code};
        s_axis_tuser  <= m;
        do @(posedge clk); while (!s_axis_tready);
        expected_results.push_back(console_step(m, code, addr));
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (expected_results.size() != 0);
    endtask

    // Receiver: long hold-off on request, else random stalls
    always @(negedge clk) begin
        if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(99) < 20) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got_result = m_axis_tdata[27:0];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                want_result = expected_results.pop_front();
                if (got_result.position !== want_result.position)
                    report_mismatch("cursor_position", got_result.position,
                                    want_result.position);
                if (got_result.cell_data !== want_result.cell_data)
                    report_mismatch("cell_data", got_result.cell_data, want_result.cell_data);
                if (got_result.scrolled !== want_result.scrolled)
                    report_mismatch("scrolled", got_result.scrolled, want_result.scrolled);
            end
        end
    end

    // Field extremes, every request kind and the corner cases of put mode
    task automatic test_directed();
        send_item(MODE_PUT, 8'h41, 11'd0);
        send_item(MODE_PUT, 8'h00, 11'h7FF);      // byte zero is an ordinary character
        send_item(MODE_PUT, 8'hFF, 11'd0);
        send_item(MODE_PUT, 8'h80, 11'd0);        // top bit set stays a raw byte
        send_item(MODE_READ, 8'h00, 11'd0);
        send_item(MODE_READ, 8'h00, 11'd1);
        send_item(MODE_READ, 8'h00, 11'd2);
        send_item(MODE_PUT, CHAR_BACKSPACE, 11'd0);
        send_item(MODE_READ, 8'h00, 11'd3);
        send_item(MODE_PUT, CHAR_NEWLINE, 11'd0);
        send_item(MODE_PUT, CHAR_BACKSPACE, 11'd0); // column 0: no effect
        send_item(MODE_READ, 8'h00, 11'd1999);
        send_item(MODE_READ, 8'h00, 11'd2000);      // just past the store
        send_item(MODE_READ, 8'hFF, 11'h7FF);
        send_item(MODE_NOP, 8'hFF, 11'h7FF);
        send_item(MODE_NOP, 8'h00, 11'd0);
        send_item(MODE_CLEAR, 8'hFF, 11'h7FF);
        send_item(MODE_READ, 8'h00, 11'd0);
        send_item(MODE_PUT, 8'h7E, 11'd0);
        wait_results_drained();
    endtask

    // Lines of text from the bottom row, so most newlines and wraps scroll
    task automatic test_text_scroll(input int n_items);
        int sent;
        int line_len;
        int pick;
        sent = 0;
        repeat (ROWS - 1) send_item(MODE_PUT, CHAR_NEWLINE, 11'($urandom));
        while (sent < n_items) begin
            pick = $urandom_range(9);
            if (pick < 5)
                line_len = 0;
            else if (pick < 9)
                line_len = $urandom_range(1, 30);
            else
                line_len = $urandom_range(COLS, COLS + 50);
            for (int i = 0; i < line_len; i++) begin
                pick = $urandom_range(99);
                if (pick < 7)
                    send_item(MODE_PUT, CHAR_BACKSPACE, 11'($urandom));
                else if (pick < 22)
                    send_item(MODE_READ, 8'($urandom), read_address());
                else if (pick < 24)
                    send_item(MODE_NOP, 8'($urandom), 11'($urandom));
                else
                    send_item(MODE_PUT, 8'($urandom), 11'($urandom));
                sent++;
            end
            send_item(MODE_PUT, CHAR_NEWLINE, 11'($urandom));
            sent++;
        end
        wait_results_drained();
    endtask

    // Receiver holds off while the sender keeps offering; then a quiet sender
    task automatic test_backpressure();
        sink_hold_cycles = 400;
        repeat (12) send_item(MODE_PUT, 8'($urandom_range(32, 126)), 11'($urandom));
        wait_results_drained();
        repeat (6) send_item(MODE_READ, 8'($urandom), read_address());
        wait_results_drained();
    endtask

    // All request kinds mixed; the first stretch runs with no idling on either side
    task automatic test_random_mix(input int n_items, input int n_quiet);
        int pick;
        for (int i = 0; i < n_items; i++) begin
            src_idle_en  = (i >= n_quiet);
            sink_idle_en = (i >= n_quiet);
            pick = $urandom_range(199);
            if (pick < 4)
                send_item(MODE_CLEAR, 8'($urandom), 11'($urandom));
            else if (pick < 10)
                send_item(MODE_NOP, 8'($urandom), 11'($urandom));
            else if (pick < 60)
                send_item(MODE_READ, 8'($urandom), read_address());
            else if (pick < 76)
                send_item(MODE_PUT, CHAR_NEWLINE, 11'($urandom));
            else if (pick < 88)
                send_item(MODE_PUT, CHAR_BACKSPACE, 11'($urandom));
            else
                send_item(MODE_PUT, 8'($urandom), 11'($urandom));
        end
        wait_results_drained();
    endtask

    initial begin
        blank_screen();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_text_scroll(700);
        test_backpressure();
        test_random_mix(400, 150);

        repeat (END_SETTLE) @(negedge clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
